FILE: sv/texture_tile_address_generator_defines.svh
// assertion macros for the texture tile address generator checker
`ifndef TEXTURE_TILE_ADDRESS_GENERATOR_DEFINES_SVH
`define TEXTURE_TILE_ADDRESS_GENERATOR_DEFINES_SVH

// checked only while out of reset
`define TTAG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TTAG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/ttag_pkg.sv
// types and constants shared by the texture tile address generator
package ttag_pkg;

  localparam int X_W        = 10;
  localparam int Y_W        = 10;
  localparam int ADDR_W     = 22;
  localparam int BYTES_W    = 4;
  localparam int WIDTH_W    = 11;
  localparam int DEPTH_W    = 2;
  localparam int STRIDE_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int ACROSS_W = 10;  // tiles across one tile row, up to 512
  localparam int YHI_W    = 8;   // tile row index
  localparam int XHI_W    = 8;   // tile column index
  localparam int TPROD_W  = 19;  // full tile index width
  localparam int TILE_W   = 17;  // tile index bits that land inside the address
  localparam int XOFF_W   = 12;  // column byte offset in a linear row
  localparam int INTRA_W  = 5;   // byte offset inside a 32-byte tile, or tile half for 32-bit texels

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXEL_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE  = 2'd2;

  // texel depth codes
  localparam logic [DEPTH_W-1:0] DEPTH_4B  = 2'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_8B  = 2'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_16B = 2'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_32B = 2'd3;

  localparam logic [BYTES_W-1:0] MOVE_2 = 4'd2;
  localparam logic [BYTES_W-1:0] MOVE_4 = 4'd4;
  localparam logic [BYTES_W-1:0] MOVE_8 = 4'd8;

  localparam logic [ADDR_W-1:0] HALF_STEP = 22'd2;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd2048;
  localparam logic [ACROSS_W-1:0] ACROSS_RESET = 10'd1;

  // one classified chunk waiting for the back end
  typedef struct packed {
    logic [ADDR_W-1:0]  row;
    logic [TILE_W-1:0]  tile;
    logic [XOFF_W-1:0]  xoff;
    logic [INTRA_W-1:0] intra;
    logic [DEPTH_W-1:0] depth;
  } q_entry_t;

endpackage

FILE: sv/ttag_if.sv
// handshake channels of the texture tile address generator
interface ttag_in_if;
  import ttag_pkg::*;
  logic           valid;
  logic           ready;
  logic [X_W-1:0] chunk_x;
  logic [Y_W-1:0] chunk_y;
  modport source (output valid, chunk_x, chunk_y, input ready);
  modport sink   (input valid, chunk_x, chunk_y, output ready);
endinterface

interface ttag_out_if;
  import ttag_pkg::*;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  linear_addr;
  logic [ADDR_W-1:0]  tiled_addr;
  logic [BYTES_W-1:0] move_bytes;
  logic               last;
  modport source (output valid, linear_addr, tiled_addr, move_bytes, last, input ready);
  modport sink   (input valid, linear_addr, tiled_addr, move_bytes, last, output ready);
endinterface

interface ttag_cfg_if;
  import ttag_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/ttag_front.sv
// front end: config registers, chunk classification and the two multiplies
module ttag_front (
  input  logic              clk,
  input  logic              rst_n,
  ttag_in_if.sink           in_ch,
  ttag_cfg_if.sink          cfg_ch,
  output ttag_pkg::q_entry_t q_entry,
  output logic              q_push,
  input  logic              q_ready
);
  import ttag_pkg::*;

  logic [ACROSS_W-1:0] across8_r, across8_nxt;
  logic [ACROSS_W-1:0] across4_r, across4_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [STRIDE_W-1:0] stride_r, stride_nxt;

  logic                st_valid_r, st_valid_nxt;
  q_entry_t            st_entry_r;
  q_entry_t            entry_nxt;

  logic [WIDTH_W:0]    wsum8, wsum4;
  logic                in_acc;
  logic [ACROSS_W-1:0] across;
  logic [YHI_W-1:0]    yhi;
  logic [XHI_W-1:0]    xhi;
  logic [ADDR_W:0]     row_prod;
  logic [TPROD_W-1:0]  tile_full;

  assign cfg_ch.ready = 1'b1;

  // tiles across per tile row, rounded up, worked out once per write
  assign wsum8 = {1'b0, cfg_ch.data[WIDTH_W-1:0]} + 12'd7;
  assign wsum4 = {1'b0, cfg_ch.data[WIDTH_W-1:0]} + 12'd3;

  always_comb begin
    across8_nxt = across8_r;
    across4_nxt = across4_r;
    depth_nxt   = depth_r;
    stride_nxt  = stride_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IMAGE_WIDTH: begin
          across8_nxt = {1'b0, wsum8[WIDTH_W:3]};
          across4_nxt = wsum4[WIDTH_W:2];
        end
        REG_TEXEL_DEPTH: depth_nxt  = cfg_ch.data[DEPTH_W-1:0];
        REG_ROW_STRIDE:  stride_nxt = cfg_ch.data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      across8_r <= ACROSS_RESET;
      across4_r <= ACROSS_RESET;
      depth_r   <= DEPTH_16B;
      stride_r  <= STRIDE_RESET;
    end else begin
      across8_r <= across8_nxt;
      across4_r <= across4_nxt;
      depth_r   <= depth_nxt;
      stride_r  <= stride_nxt;
    end
  end

  // classify the chunk by texel depth
  always_comb begin
    entry_nxt.depth = depth_r;
    unique case (depth_r)
      DEPTH_4B: begin
        across          = across8_r;
        yhi             = {1'b0, in_ch.chunk_y[9:3]};
        xhi             = {1'b0, in_ch.chunk_x[9:3]};
        entry_nxt.xoff  = {3'b0, in_ch.chunk_x[9:3], 2'b0};
        entry_nxt.intra = {in_ch.chunk_y[2:0], 2'b0};
      end
      DEPTH_8B: begin
        across          = across8_r;
        yhi             = in_ch.chunk_y[9:2];
        xhi             = {1'b0, in_ch.chunk_x[9:3]};
        entry_nxt.xoff  = {2'b0, in_ch.chunk_x[9:3], 3'b0};
        entry_nxt.intra = {in_ch.chunk_y[1:0], 3'b0};
      end
      DEPTH_16B: begin
        across          = across4_r;
        yhi             = in_ch.chunk_y[9:2];
        xhi             = in_ch.chunk_x[9:2];
        entry_nxt.xoff  = {1'b0, in_ch.chunk_x[9:2], 3'b0};
        entry_nxt.intra = {in_ch.chunk_y[1:0], 3'b0};
      end
      DEPTH_32B: begin
        across          = across4_r;
        yhi             = in_ch.chunk_y[9:2];
        xhi             = in_ch.chunk_x[9:2];
        entry_nxt.xoff  = {in_ch.chunk_x, 2'b0};
        entry_nxt.intra = {in_ch.chunk_y[1:0], in_ch.chunk_x[1:0], 1'b0};
      end
    endcase
    row_prod       = (ADDR_W+1)'(stride_r) * (ADDR_W+1)'(in_ch.chunk_y);
    tile_full      = TPROD_W'(across) * TPROD_W'(yhi) + TPROD_W'(xhi);
    entry_nxt.row  = row_prod[ADDR_W-1:0];
    entry_nxt.tile = tile_full[TILE_W-1:0];
  end

  assign in_ch.ready = !st_valid_r || q_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign q_push      = st_valid_r;
  assign q_entry     = st_entry_r;

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (in_acc) begin
      st_valid_nxt = 1'b1;
    end else if (q_ready) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_entry_r <= entry_nxt;
    end
  end

endmodule

FILE: sv/ttag_queue.sv
// short register queue between the front and back ends
module ttag_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ttag_pkg::q_entry_t push_entry,
  input  logic               push_valid,
  output logic               push_ready,
  output ttag_pkg::q_entry_t head_entry,
  output logic               head_valid,
  input  logic               pop
);
  import ttag_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_FULL;
  assign head_valid = count_r != '0;
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: sv/ttag_back.sv
// back end: forms the byte moves and holds them in the output register
module ttag_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ttag_pkg::q_entry_t head_entry,
  input  logic               head_valid,
  output logic               pop,
  ttag_out_if.source         out_ch
);
  import ttag_pkg::*;

  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  lin_r, lin_nxt;
  logic [ADDR_W-1:0]  til_r, til_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic               last_r, last_nxt;
  logic               phase_r, phase_nxt;   // second halfword of a 32-bit pixel

  logic               load_en;
  logic               split;
  logic [TILE_W-1:0]  tile_sel;

  assign load_en = !out_valid_r || out_ch.ready;
  assign split   = head_entry.depth == DEPTH_32B;

  always_comb begin
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    pop           = 1'b0;
    last_nxt      = 1'b1;
    if (load_en) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        if (split && !phase_r) begin
          phase_nxt = 1'b1;
          last_nxt  = 1'b0;
        end else begin
          phase_nxt = 1'b0;
          pop       = 1'b1;
        end
      end
    end
  end

  // second half sits 2 bytes on in the image and 32 bytes on in the tile
  // 32-bit tiles span 64 bytes: two 32-byte halves per tile index
  always_comb begin
    tile_sel = split ? {head_entry.tile[TILE_W-2:0], phase_r} : head_entry.tile;
    lin_nxt  = head_entry.row + ADDR_W'(head_entry.xoff) + (phase_r ? HALF_STEP : '0);
    til_nxt  = {tile_sel, head_entry.intra};
    unique case (head_entry.depth)
      DEPTH_4B:  bytes_nxt = MOVE_4;
      DEPTH_8B:  bytes_nxt = MOVE_8;
      DEPTH_16B: bytes_nxt = MOVE_8;
      DEPTH_32B: bytes_nxt = MOVE_2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && head_valid) begin
      lin_r   <= lin_nxt;
      til_r   <= til_nxt;
      bytes_r <= bytes_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.linear_addr = lin_r;
  assign out_ch.tiled_addr  = til_r;
  assign out_ch.move_bytes  = bytes_r;
  assign out_ch.last        = last_r;

endmodule

FILE: sv/texture_tile_address_generator.sv
// top level of the texture tile address generator
//
//   channel | direction | word                                        | handshake
//   --------+-----------+---------------------------------------------+-----------
//   in_ch   | in        | chunk_x, chunk_y                            | valid/ready
//   out_ch  | out       | linear_addr, tiled_addr, move_bytes, last   | valid/ready
//   cfg_ch  | in        | index, data (image_width, depth, stride)    | valid/ready
//
// 4-, 8- and 16-bit texels: one chunk per cycle, one move each, while out_ch is ready.
// 32-bit texels: two moves per chunk, one move a cycle while out_ch is ready.
// a chunk's first move passes through the stage, the queue and the output register.
// reset empties the stage, the queue and the output register and restores register defaults.
// a stalled output fills the QUEUE_DEPTH-word queue and the stage before the input stalls.
// cfg_ch is always ready.
module texture_tile_address_generator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  ttag_in_if.sink    in_ch,
  ttag_out_if.source out_ch,
  ttag_cfg_if.sink   cfg_ch
);
  import ttag_pkg::*;

  q_entry_t push_entry;
  logic     push_valid;
  logic     push_ready;
  q_entry_t head_entry;
  logic     head_valid;
  logic     pop;

  ttag_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_entry (push_entry),
    .q_push  (push_valid),
    .q_ready (push_ready)
  );

  ttag_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head_entry (head_entry),
    .head_valid (head_valid),
    .pop        (pop)
  );

  ttag_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: sv/ttag_checker.sv
// port-level checks for the texture tile address generator, bound to the top level
`include "texture_tile_address_generator_defines.svh"

module ttag_checker (
  input logic        clk,
  input logic        rst_n,
  ttag_out_if.source out_ch
);
  import ttag_pkg::*;

  // the output register is empty the cycle after reset
  `TTAG_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_ch.valid, "output valid after reset")

  // a stalled move holds its word
  `TTAG_ASSERT(a_stall_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable({out_ch.linear_addr, out_ch.tiled_addr, out_ch.move_bytes, out_ch.last}), "stalled move changed")

  // only the first half of a 32-bit pixel is a non-final move
  `TTAG_ASSERT(a_first_half_bytes, clk, rst_n, out_ch.valid && !out_ch.last |-> out_ch.move_bytes == MOVE_2, "non-final move is not a halfword")

  // the second half follows at once, 2 bytes on linear and 32 bytes on tiled
  `TTAG_ASSERT(a_second_half, clk, rst_n, out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid && out_ch.last && out_ch.move_bytes == MOVE_2 && out_ch.linear_addr == ADDR_W'($past(out_ch.linear_addr) + HALF_STEP) && out_ch.tiled_addr == ADDR_W'($past(out_ch.tiled_addr) + 22'd32), "second halfword move wrong")

endmodule

bind texture_tile_address_generator ttag_checker u_ttag_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch)
);

FILE: bench/tb_texture_tile_address_generator.sv
// testbench for the texture tile address generator: predicted byte moves checked per word
module tb_texture_tile_address_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import ttag_pkg::*;

  localparam int HOLD_CYCLES = 120;
  localparam int PHASES      = 13;
  localparam int PHASE_WORDS = 100;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    logic [ADDR_W-1:0]  lin;
    logic [ADDR_W-1:0]  til;
    logic [BYTES_W-1:0] nbytes;
    logic               last;
  } move_t;

  class move_scoreboard;
    logic [WIDTH_W-1:0]  img_width;
    logic [DEPTH_W-1:0]  depth;
    logic [STRIDE_W-1:0] stride;
    move_t               pending_moves[$];
    int                  errors;
    int                  chunks;
    int                  moves;
    int                  reg_writes;
    int                  depth_hits[4];

    function new();
      img_width = 11'd1;
      depth     = DEPTH_16B;
      stride    = STRIDE_RESET;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_IMAGE_WIDTH: img_width = data[WIDTH_W-1:0];
        REG_TEXEL_DEPTH: depth = data[DEPTH_W-1:0];
        REG_ROW_STRIDE: stride = data[STRIDE_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_move(logic [63:0] lin, logic [63:0] til, logic [BYTES_W-1:0] nb,
                            logic lst);
      move_t m;
      m.lin    = lin[ADDR_W-1:0];
      m.til    = til[ADDR_W-1:0];
      m.nbytes = nb;
      m.last   = lst;
      pending_moves.push_back(m);
    endfunction

    // works out the moves one chunk causes under the current register values
    function void note_chunk(logic [X_W-1:0] cx, logic [Y_W-1:0] cy);
      logic [63:0] x, y, row, a8, a4, til, p;
      x   = 64'(cx);
      y   = 64'(cy);
      row = 64'(stride) * y;
      a8  = (64'(img_width) + 64'd7) >> 3;
      a4  = (64'(img_width) + 64'd3) >> 2;
      chunks++;
      depth_hits[depth]++;
      case (depth)
        DEPTH_4B: begin
          x   = x & ~64'd7;
          til = (((y & 64'd7) << 3) + (a8 * (y >> 3) + (x >> 3)) * 64'd64) >> 1;
          push_move(row + (x >> 1), til, MOVE_4, 1'b1);
        end
        DEPTH_8B: begin
          x   = x & ~64'd7;
          til = ((y & 64'd3) << 3) + (a8 * (y >> 2) + (x >> 3)) * 64'd32;
          push_move(row + x, til, MOVE_8, 1'b1);
        end
        DEPTH_16B: begin
          x   = x & ~64'd3;
          til = (((y & 64'd3) << 2) + (a4 * (y >> 2) + (x >> 2)) * 64'd16) << 1;
          push_move(row + (x << 1), til, MOVE_8, 1'b1);
        end
        default: begin
          // halfword index of the first half; the second half sits 16 halfwords on
          p = ((a4 * (y >> 2) + (x >> 2)) << 5) + ((y & 64'd3) << 2) + (x & 64'd3);
          push_move(row + (x << 2), p << 1, MOVE_2, 1'b0);
          push_move(row + (x << 2) + 64'd2, (p + 64'd16) << 1, MOVE_2, 1'b1);
        end
      endcase
    endfunction

    task check_move(logic [ADDR_W-1:0] lin, logic [ADDR_W-1:0] til,
                    logic [BYTES_W-1:0] nb, logic lst);
      move_t e;
      moves++;
      if (pending_moves.size() == 0) begin
        report_mismatch($sformatf("move with nothing expected lin=%0h til=%0h", lin, til));
        return;
      end
      e = pending_moves.pop_front();
      if (lin !== e.lin)
        report_mismatch($sformatf("linear_addr %0h, expected %0h", lin, e.lin));
      if (til !== e.til)
        report_mismatch($sformatf("tiled_addr %0h, expected %0h", til, e.til));
      if (nb !== e.nbytes)
        report_mismatch($sformatf("move_bytes %0d, expected %0d", nb, e.nbytes));
      if (lst !== e.last)
        report_mismatch($sformatf("last %0b, expected %0b", lst, e.last));
    endtask

    function int pending();
      return pending_moves.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   long_hold_req;

  move_scoreboard sb;

  int dir_x[6] = '{0, 1023, 5, 1023, 0, 13};
  int dir_y[6] = '{0, 1023, 3, 0, 1023, 9};

  ttag_in_if  in_ch();
  ttag_out_if out_ch();
  ttag_cfg_if cfg_ch();

  texture_tile_address_generator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("texture_tile_address_generator verification failed");
    $finish;
  end

  // watch all three channels at the edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_chunk(in_ch.chunk_x, in_ch.chunk_y);
      if (out_ch.valid && out_ch.ready)
        sb.check_move(out_ch.linear_addr, out_ch.tiled_addr, out_ch.move_bytes, out_ch.last);
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task set_config(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] d,
                  logic [CFG_DATA_W-1:0] s);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_TEXEL_DEPTH, d);
    write_reg(REG_ROW_STRIDE, s);
    cfg_ch.valid <= 1'b0;
  endtask

  task send_chunk(int x, int y);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.chunk_x <= X_W'(x);
    in_ch.chunk_y <= Y_W'(y);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // all moves in, then a quiet wait before any register write
  task drain_moves();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task run_directed();
    for (int i = 0; i < 6; i++) send_chunk(dir_x[i], dir_y[i]);
    drain_moves();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] w, s, d;
    sb = new();
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.chunk_x <= '0;
    in_ch.chunk_y <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_IMAGE_WIDTH;
    cfg_ch.data   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults straight out of reset: 16-bit texels
    run_directed();
    // 4-bit texels, widest image and stride
    set_config(13'd1024, {11'h5A5, DEPTH_4B}, 13'd4096);
    run_directed();
    // 8-bit texels, zero width and zero stride
    set_config(13'd0, {11'h000, DEPTH_8B}, 13'd0);
    run_directed();
    // 32-bit texels, registers beyond range so addresses wrap
    set_config(13'h1FFF, {11'h7FF, DEPTH_32B}, 13'h1FFF);
    run_directed();

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0: w = 13'd0;
        1: w = 13'd1;
        2: w = 13'd1024;
        3: w = 13'h1FFF;
        default: w = {2'($urandom), 11'($urandom_range(1, 1024))};
      endcase
      case ($urandom_range(0, 5))
        0: s = 13'd0;
        1: s = 13'd1;
        2: s = 13'd4096;
        3: s = 13'h1FFF;
        default: s = 13'($urandom_range(1, 4096));
      endcase
      d = {11'($urandom), 2'(ph % 4)};
      set_config(w, d, s);
      idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (ph == 3) begin
        // sender keeps offering while the result side sits still
        idle_on       = 1'b0;
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_WORDS; i++)
        send_chunk($urandom_range(0, 1023), $urandom_range(0, 1023));
      drain_moves();
    end

    $display("covered %0d chunks (4b %0d, 8b %0d, 16b %0d, 32b %0d), %0d moves checked",
             sb.chunks, sb.depth_hits[0], sb.depth_hits[1], sb.depth_hits[2],
             sb.depth_hits[3], sb.moves);
    $display("%0d register writes incl. zero and out-of-range width/stride, one long output hold",
             sb.reg_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("texture_tile_address_generator verification clean");
    end else begin
      $display("texture_tile_address_generator verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/ttag_pkg.sv
sv/ttag_if.sv
sv/ttag_front.sv
sv/ttag_queue.sv
sv/ttag_back.sv
sv/texture_tile_address_generator.sv
sv/ttag_checker.sv
bench/tb_texture_tile_address_generator.sv
